// ===== rtl/rfm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfm_pkg: shared types and constants of the redundant frame merge core
// Widths, slot table size, queue size, result codes and the queued item.
// ----------------------------------------------------------------------------
package rfm_pkg;

    // slot table
    localparam int SLOTS   = 16;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // decoupling queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // field widths
    localparam int FRAME_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int OUT_W      = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int FPP_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FPP    = 1'b1;
    localparam logic [FPP_W-1:0]     FPP_RESET  = 4'd3;

    // request actions
    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // result codes
    localparam logic [OUT_W-1:0] OUT_DELIVERED  = 3'd0;
    localparam logic [OUT_W-1:0] OUT_DUPLICATE  = 3'd1;
    localparam logic [OUT_W-1:0] OUT_INCOMPLETE = 3'd2;
    localparam logic [OUT_W-1:0] OUT_NO_SLOT    = 3'd3;
    localparam logic [OUT_W-1:0] OUT_REFUSED    = 3'd4;
    localparam logic [OUT_W-1:0] OUT_BUSY       = 3'd5;
    localparam logic [OUT_W-1:0] OUT_RELEASED   = 3'd6;
    localparam logic [OUT_W-1:0] OUT_UNKNOWN    = 3'd7;

    typedef enum logic [1:0] {
        KIND_ARRIVAL,   // complete frame arrival
        KIND_PARTIAL,   // incomplete frame arrival
        KIND_RELEASE    // consumer gives a handle back
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [FRAME_W-1:0]   frame_id;
        logic                 port;
        logic [STAMP_W-1:0]   timestamp;
        logic                 accept;
    } t_item;

    typedef struct packed {
        logic               enable;
        logic [FPP_W-1:0]   fpp;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/redundant_frame_merge_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_frame_merge_core: first-complete-frame merge of two redundant ports
// Passes on only the first complete frame per media timestamp, keeps the
// handles the consumer holds in a slot table and answers releases.
// ----------------------------------------------------------------------------
// Every request (arrival or release) gives exactly one result, in request
// order. Requests enter a two-entry queue; the slot engine takes one request
// at a time. Busy, incomplete and duplicate arrivals are decided when the
// engine picks the request up; the result is valid in the next cycle. Complete
// arrivals and releases walk the slot table one slot per cycle from slot 0
// while the result register is free, and search at most min(2*frames_per_port,
// 16) slots before a no-slot or unknown result. The slot walk sets the rate.
// Results sit in an output register, so the queue keeps taking requests while
// a result waits. The slot valid bits clear at reset; no clearing pass.
// Configuration (index 0 block_enable, index 1 frames_per_port) is to be
// written while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module redundant_frame_merge_core import rfm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_action,
    input  logic [FRAME_W-1:0]      i_frame_id,
    input  logic                    i_port,
    input  logic [STAMP_W-1:0]      i_timestamp,
    input  logic                    i_frame_complete,
    input  logic                    i_consumer_accept,
    // result channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_W-1:0]        o_outcome,
    output logic [FRAME_W-1:0]      o_frame_out,
    output logic                    o_return_port,
    output logic [SLOT_OUT_W-1:0]   o_slot_used
);

    t_cfg       r_cfg;
    t_q_stat    w_q_stat;
    t_item      w_push_item;
    t_item      w_head_item;
    logic       w_push;
    logic       w_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.fpp    <= FPP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                CFG_FPP:    r_cfg.fpp    <= i_cfg_data[FPP_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // intake: tags requests and pushes them while the queue has room
    rfm_front u_front (
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_frame_id         (i_frame_id),
        .i_port             (i_port),
        .i_timestamp        (i_timestamp),
        .i_frame_complete   (i_frame_complete),
        .i_consumer_accept  (i_consumer_accept),
        .i_q_stat           (w_q_stat),
        .o_push             (w_push),
        .o_item             (w_push_item)
    );

    rfm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_item     (w_push_item),
        .i_pop      (w_pop),
        .o_item     (w_head_item),
        .o_stat     (w_q_stat)
    );

    // slot engine with registered result
    rfm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_item         (w_head_item),
        .i_q_stat       (w_q_stat),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_outcome      (o_outcome),
        .o_frame_out    (o_frame_out),
        .o_return_port  (o_return_port),
        .o_slot_used    (o_slot_used)
    );

`ifndef SYNTHESIS
    // a reset leaves no result pending
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // busy and unknown-handle results name neither a port nor a slot
    a_no_port_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OUT_BUSY || o_outcome == OUT_UNKNOWN))
        |-> (!o_return_port && o_slot_used == '0))
        else $error("busy/unknown result carries port or slot");

    // a delivered frame is never sent back to a port
    a_delivered_no_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outcome == OUT_DELIVERED) |-> !o_return_port)
        else $error("delivered frame returned to a port");

    // the queue is never full and empty at once
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue full and empty together");
`endif

endmodule

// ===== rtl/rfm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfm_front: request intake
// Takes requests off the input channel and tags each one by kind.
// ----------------------------------------------------------------------------
module rfm_front import rfm_pkg::*; (
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_action,
    input  logic [FRAME_W-1:0]  i_frame_id,
    input  logic                i_port,
    input  logic [STAMP_W-1:0]  i_timestamp,
    input  logic                i_frame_complete,
    input  logic                i_consumer_accept,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_item               o_item
);

    t_kind w_kind;

    always_comb begin
        if (i_action == ACT_RELEASE) begin
            w_kind = KIND_RELEASE;
        end else if (i_frame_complete) begin
            w_kind = KIND_ARRIVAL;
        end else begin
            w_kind = KIND_PARTIAL;
        end
    end

    assign o_stall = i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    assign o_item.kind      = w_kind;
    assign o_item.frame_id  = i_frame_id;
    assign o_item.port      = i_port;
    assign o_item.timestamp = i_timestamp;
    assign o_item.accept    = i_consumer_accept;

endmodule

// ===== rtl/rfm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfm_queue: short request queue
// Small FIFO that lets intake and slot engine stall independently.
// ----------------------------------------------------------------------------
module rfm_queue import rfm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic [Q_PTR_W-1:0]   n_wr;
    logic [Q_PTR_W-1:0]   n_rd;
    logic [Q_CNT_W-1:0]   n_cnt;
    logic                 w_push;
    logic                 w_pop;

    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_item = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/rfm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfm_back: slot engine
// Tracks the current timestamp, walks the slot table one slot per cycle while
// the result register is free, and registers one result per request.
// ----------------------------------------------------------------------------
module rfm_back import rfm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_item                   i_item,
    input  t_q_stat                 i_q_stat,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_W-1:0]        o_outcome,
    output logic [FRAME_W-1:0]      o_frame_out,
    output logic                    o_return_port,
    output logic [SLOT_OUT_W-1:0]   o_slot_used
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                   r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    t_item                  r_cur, n_cur;
    logic [STAMP_W-1:0]     r_stamp, n_stamp;
    logic                   r_delivered, n_delivered;
    logic [SLOTS-1:0]       r_slot_valid, n_slot_valid;
    logic [FRAME_W-1:0]     r_slot_frame [SLOTS];
    logic                   r_slot_port [SLOTS];

    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_outcome;
    logic [FRAME_W-1:0]     r_frame_out;
    logic                   r_return_port;
    logic [SLOT_OUT_W-1:0]  r_slot_used;

    logic                   w_out_free;
    logic                   w_load;
    logic [OUT_W-1:0]       w_outcome;
    logic [FRAME_W-1:0]     w_frame;
    logic                   w_rport;
    logic [SLOT_OUT_W-1:0]  w_slot_out;
    logic                   w_slot_we;
    logic [SLOT_W-1:0]      w_slot;
    logic [FPP_W:0]         w_dbl;
    logic [CNT_W-1:0]       w_limit;
    logic                   w_fresh;

    // searched slots: twice the per-port count, capped at the table size
    assign w_dbl   = {i_cfg.fpp, 1'b0};
    assign w_limit = (32'(w_dbl) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(w_dbl);
    assign w_slot  = r_idx[SLOT_W-1:0];
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fresh = (i_item.timestamp != r_stamp);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cur        = r_cur;
        n_stamp      = r_stamp;
        n_delivered  = r_delivered;
        n_slot_valid = r_slot_valid;
        o_pop        = 1'b0;
        w_load       = 1'b0;
        w_outcome    = OUT_BUSY;
        w_frame      = r_cur.frame_id;
        w_rport      = 1'b0;
        w_slot_out   = '0;
        w_slot_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty && w_out_free) begin
                    o_pop   = 1'b1;
                    n_cur   = i_item;
                    n_idx   = '0;
                    w_frame = i_item.frame_id;
                    if (i_item.kind == KIND_RELEASE) begin
                        n_state = ST_SCAN;
                    end else if (!i_cfg.enable) begin
                        w_load    = 1'b1;
                        w_outcome = OUT_BUSY;
                    end else begin
                        n_stamp     = i_item.timestamp;
                        n_delivered = w_fresh ? 1'b0 : r_delivered;
                        if (i_item.kind == KIND_PARTIAL) begin
                            w_load    = 1'b1;
                            w_outcome = OUT_INCOMPLETE;
                            w_rport   = i_item.port;
                        end else if (n_delivered) begin
                            w_load    = 1'b1;
                            w_outcome = OUT_DUPLICATE;
                            w_rport   = i_item.port;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (w_out_free) begin
                    if (r_idx >= w_limit) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                        if (r_cur.kind == KIND_RELEASE) begin
                            w_outcome = OUT_UNKNOWN;
                        end else begin
                            w_outcome = OUT_NO_SLOT;
                            w_rport   = r_cur.port;
                        end
                    end else if (r_cur.kind == KIND_RELEASE) begin
                        if (r_slot_valid[w_slot] &&
                            r_slot_frame[w_slot] == r_cur.frame_id) begin
                            n_slot_valid[w_slot] = 1'b0;
                            w_load     = 1'b1;
                            w_outcome  = OUT_RELEASED;
                            w_rport    = r_slot_port[w_slot];
                            w_slot_out = SLOT_OUT_W'(r_idx);
                            n_state    = ST_IDLE;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end else if (!r_slot_valid[w_slot]) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                        if (r_cur.accept) begin
                            n_slot_valid[w_slot] = 1'b1;
                            w_slot_we   = 1'b1;
                            n_delivered = 1'b1;
                            w_outcome   = OUT_DELIVERED;
                            w_slot_out  = SLOT_OUT_W'(r_idx);
                        end else begin
                            w_outcome = OUT_REFUSED;
                            w_rport   = r_cur.port;
                        end
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_stamp      <= '0;
            r_delivered  <= 1'b0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_stamp      <= n_stamp;
            r_delivered  <= n_delivered;
            r_slot_valid <= n_slot_valid;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (w_load) begin
            r_outcome     <= w_outcome;
            r_frame_out   <= w_frame;
            r_return_port <= w_rport;
            r_slot_used   <= w_slot_out;
        end
        if (w_slot_we) begin
            r_slot_frame[w_slot] <= r_cur.frame_id;
            r_slot_port[w_slot]  <= r_cur.port;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_outcome     = r_outcome;
    assign o_frame_out   = r_frame_out;
    assign o_return_port = r_return_port;
    assign o_slot_used   = r_slot_used;

endmodule
